@@ rtl/fcl_pkg.sv @@
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared types and constants for the fully connected layer forward core.
// ----------------------------------------------------------------------------
`default_nettype none
package fcl_pkg;

  localparam int ACC_W = 40;

  typedef enum logic [1:0] {
    KIND_WEIGHT = 2'd0,
    KIND_BIAS   = 2'd1,
    KIND_ELEM   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_OREAD,
    ST_OCALC,
    ST_OUT
  } state_t;

  localparam logic CFG_IN_LEN  = 1'b0;
  localparam logic CFG_OUT_LEN = 1'b1;

  // Control from the sequencer to the serial multiplier.
  typedef struct packed {
    logic start;
  } mul_ctrl_t;

  // Status from the serial multiplier back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage
`default_nettype wire

@@ rtl/fully_connected_layer_forward_core.sv @@
// ----------------------------------------------------------------------------
// fully_connected_layer_forward_core
// y = W*x + b in Q8.8 with a bit-serial shared multiplier.
// Weight, bias and element beats are accepted only while idle. For each active
// row the element then goes through a read, the 16-step serial multiplier that
// all rows share, and an accumulate. After a final element, or once the input
// length is reached, each result row is biased, rounded and held until taken.
// Synchronous reset clears accumulators, count and control; the weight and
// bias memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module fully_connected_layer_forward_core #(
  parameter int IN_MAX    = 64,
  parameter int OUT_MAX   = 16,
  parameter int FRAC_BITS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [3:0]  row,
  input  wire logic [5:0]  col,
  input  wire logic signed [15:0] value,
  input  wire logic        final_elem,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [3:0]       out_row,
  output logic signed [15:0] out_value,
  output logic             saturated,
  output logic             last_row,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data
);
  import fcl_pkg::*;

  localparam int RW = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
  localparam int CW = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
  localparam int NW = $clog2(IN_MAX + 1);
  localparam int AW = (IN_MAX * OUT_MAX > 1) ? $clog2(IN_MAX * OUT_MAX) : 1;

  logic [6:0] in_len;
  logic [4:0] out_len;
  logic [15:0] wmem [IN_MAX*OUT_MAX];
  logic [15:0] bmem [OUT_MAX];
  logic [ACC_W-1:0] acc [OUT_MAX];

  state_t state, state_next;
  logic [RW-1:0] r;
  logic [NW:0]   ecnt;
  logic signed [15:0] elem;
  logic          fin;
  logic signed [15:0] wrd, brd;
  logic [ACC_W-1:0] sum;
  logic [15:0] res_val;
  logic        res_sat;
  mul_ctrl_t   mctrl;
  mul_stat_t   mstat;
  logic signed [31:0] prod;

  // Effective lengths clamped into range.
  logic [NW:0] n_eff;
  logic [RW:0] m_eff;
  always_comb begin
    if (in_len == 7'd0) n_eff = (NW+1)'(1);
    else if (32'(in_len) > IN_MAX) n_eff = (NW+1)'(IN_MAX);
    else n_eff = (NW+1)'(in_len);
    if (out_len == 5'd0) m_eff = (RW+1)'(1);
    else if (32'(out_len) > OUT_MAX) m_eff = (RW+1)'(OUT_MAX);
    else m_eff = (RW+1)'(out_len);
  end

  logic in_acc;
  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign mctrl.start = (state == ST_MUL) && !mstat.busy && !mstat.done;

  logic last_r;
  assign last_r = ((RW+1)'(r) + (RW+1)'(1) == m_eff);
  logic col_ok;
  assign col_ok = (ecnt < (NW+1)'(IN_MAX));

  fcl_serial_mul u_mul (
    .clk(clk), .rst(rst), .ctrl(mctrl), .a(wrd), .b(elem), .stat(mstat), .prod(prod)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_len  <= 7'd64;
      out_len <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IN_LEN) in_len <= cfg_data;
      else out_len <= cfg_data[4:0];
    end
  end

  // Memories: writes from accepted beats, registered reads.
  always_ff @(posedge clk) begin
    if (in_acc && kind == KIND_WEIGHT && 32'(row) < OUT_MAX && 32'(col) < IN_MAX)
      wmem[AW'(32'(row) * IN_MAX + 32'(col))] <= value;
    if (in_acc && kind == KIND_BIAS && 32'(row) < OUT_MAX)
      bmem[RW'(row)] <= value;
    wrd <= wmem[AW'(32'(r) * IN_MAX + 32'(ecnt[CW-1:0]))];
    brd <= bmem[r];
  end

  // Output rounding and saturation.
  logic [ACC_W-1:0] rnd;
  logic [ACC_W-1:0] shf;
  always_comb begin
    rnd = sum + ((FRAC_BITS > 0) ? (ACC_W'(1) << (FRAC_BITS - 1)) : '0);
    shf = ACC_W'($signed(rnd) >>> FRAC_BITS);
    if (!shf[ACC_W-1] && shf[ACC_W-2:15] != '0) begin
      res_val = 16'h7fff; res_sat = 1'b1;
    end else if (shf[ACC_W-1] && shf[ACC_W-2:15] != '1) begin
      res_val = 16'h8000; res_sat = 1'b1;
    end else begin
      res_val = shf[15:0]; res_sat = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && kind == KIND_ELEM) begin
        state_next = ST_READ;
      end
      ST_READ:  state_next = col_ok ? ST_MUL : ST_ACC;
      ST_MUL:   if (mstat.done) state_next = ST_ACC;
      ST_ACC: begin
        if (!last_r) state_next = ST_READ;
        else if (fin || ecnt + (NW+1)'(1) >= n_eff) state_next = ST_OREAD;
        else state_next = ST_IDLE;
      end
      ST_OREAD: state_next = ST_OCALC;
      ST_OCALC: state_next = ST_OUT;
      ST_OUT: if (out_valid && !out_stall) begin
        state_next = last_r ? ST_IDLE : ST_OREAD;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      r    <= '0;
      ecnt <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < OUT_MAX; i++) acc[i] <= '0;
    end else begin
      case (state)
        ST_IDLE: if (in_acc && kind == KIND_ELEM) begin
          elem <= value;
          fin  <= final_elem;
          r    <= '0;
        end
        ST_ACC: begin
          if (col_ok) acc[r] <= acc[r] + ACC_W'(prod);
          if (!last_r) r <= r + RW'(1);
          else begin
            r <= '0;
            ecnt <= ecnt + (NW+1)'(1);
          end
        end
        ST_OREAD: ;
        ST_OCALC: begin
          sum <= acc[r] + (ACC_W'(brd) << FRAC_BITS);
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_row   <= 4'(r);
            out_value <= res_val;
            saturated <= res_sat;
            last_row  <= last_r;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_r) begin
              r <= '0;
              ecnt <= '0;
              for (int i = 0; i < OUT_MAX; i++) acc[i] <= '0;
            end else r <= r + RW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Assertions.
  a_no_in_when_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_only_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == ST_OUT)) else $error("result outside output phase");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid) else $error("config ready during output");
endmodule
`default_nettype wire

@@ rtl/fcl_serial_mul.sv @@
// ----------------------------------------------------------------------------
// fcl_serial_mul
// Bit-serial signed 16 x 16 multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module fcl_serial_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire fcl_pkg::mul_ctrl_t ctrl,
  input  wire logic signed [15:0] a,
  input  wire logic signed [15:0] b,
  output fcl_pkg::mul_stat_t      stat,
  output logic signed [31:0]      prod
);
  import fcl_pkg::*;

  logic [4:0]         cnt;
  logic               busy;
  logic signed [31:0] mcand;
  logic [15:0]        mplier;
  logic signed [31:0] accum;
  logic               done;

  // Shift-and-add: the top multiplier bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        mcand  <= 32'(a);
        mplier <= b;
        accum  <= '0;
      end else if (busy) begin
        if (mplier[0]) begin
          if (cnt == 5'd15) accum <= accum - mcand;
          else accum <= accum + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod      = accum;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire
